// ----- sv/hmtri_pkg.sv -----
// Shared types and codes for the heightmap triangle height sampler.
`timescale 1ns / 1ps
package hmtri_pkg;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH     = 3'd0,
    REG_MAP_LENGTH    = 3'd1,
    REG_X_GRID_SCALE  = 3'd2,
    REG_Z_GRID_SCALE  = 3'd3,
    REG_HEIGHT_GAIN   = 3'd4,
    REG_HEIGHT_OFFSET = 3'd5
  } reg_index_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned SIZE_W      = 10;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;
  localparam logic [31:0] GAIN_RESET = 32'd128;

endpackage

// ----- sv/heightmap_triangle_height_sampler_top.sv -----
// Top level of the heightmap triangle height sampler.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_stall    | cmd, pixel_column, pixel_row, pixel_value,
//           |                        | query_x, query_z
//  out      | out_valid / out_stall  | height, in_range (one item per query)
//  config   | cfg_write              | cfg_index, cfg_data
//
// One item per cycle unless stalled; stages 1 to 6 lie between accept and output.
// The rate is set by the four-bank heightmap: each corner of a cell sits in its own
// bank (column parity x row parity), so all four are read in one cycle.
// rst clears control state and the config registers; heightmap content is undefined.
// A stalled output freezes the whole pipeline; in_stall follows it in the same cycle.
`timescale 1ns / 1ps
module heightmap_triangle_height_sampler_top
  import hmtri_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_LENGTH = 512,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  logic [8:0]             pixel_column,
  input  logic [8:0]             pixel_row,
  input  logic [7:0]             pixel_value,
  input  logic signed [31:0]     query_x,
  input  logic signed [31:0]     query_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     height,
  output logic                   in_range
);

  localparam int F   = FRAC_BITS;
  localparam int CW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW  = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
  localparam int CBW = (CW > 1) ? CW - 1 : 1;
  localparam int RBW = (RW > 1) ? RW - 1 : 1;
  localparam int AW  = CBW + RBW;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int LW  = $clog2(MAX_LENGTH + 1);
  localparam int IW  = 64 - 2 * F;      // integer part of a grid position
  localparam int TW  = F + 12;          // row-interpolated value
  localparam int HW  = 2 * F + 14;      // cell-interpolated value
  localparam int MW  = F + 9;           // magnitude of the floored height
  localparam int PW  = MW + 32;         // gain product
  localparam logic [31:0] SCALE_RESET  = 32'(8)   << F;
  localparam logic [31:0] OFFSET_RESET = 32'(200) << F;
  localparam logic [F:0]  ONE = {1'b1, {F{1'b0}}};

  // ---------------- configuration ----------------
  logic [SIZE_W-1:0] map_width, map_length;
  logic [31:0]       x_grid_scale, z_grid_scale, height_gain;
  logic signed [31:0] height_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width     <= SIZE_RESET;
      map_length    <= SIZE_RESET;
      x_grid_scale  <= SCALE_RESET;
      z_grid_scale  <= SCALE_RESET;
      height_gain   <= GAIN_RESET;
      height_offset <= OFFSET_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAP_WIDTH:     map_width     <= cfg_data[SIZE_W-1:0];
        REG_MAP_LENGTH:    map_length    <= cfg_data[SIZE_W-1:0];
        REG_X_GRID_SCALE:  x_grid_scale  <= cfg_data;
        REG_Z_GRID_SCALE:  z_grid_scale  <= cfg_data;
        REG_HEIGHT_GAIN:   height_gain   <= cfg_data;
        REG_HEIGHT_OFFSET: height_offset <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sizes in use, saturated to [2, MAX]
  logic [31:0]   w32, l32;
  logic [WW-1:0] w;
  logic [LW-1:0] l;
  always_comb begin
    if (32'(map_width) < 32'd2)              w32 = 32'd2;
    else if (32'(map_width) > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    else                                     w32 = 32'(map_width);
    if (32'(map_length) < 32'd2)               l32 = 32'd2;
    else if (32'(map_length) > 32'(MAX_LENGTH)) l32 = 32'(MAX_LENGTH);
    else                                       l32 = 32'(map_length);
  end
  assign w = w32[WW-1:0];
  assign l = l32[LW-1:0];

  // whole pipeline advances unless the output holds a stalled item
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- stage 1: scale to grid, load address ----------------
  logic               s1_v, s1_cmd, s1_we;
  logic signed [65:0] s1_px, s1_pz;
  logic [CW-1:0]      s1_wcol;
  logic [RW-1:0]      s1_wrow;
  logic [7:0]         s1_wdata;
  logic [31:0]        wcol32, wrow32;

  assign wcol32 = 32'(pixel_column);
  assign wrow32 = l32 - 32'd1 - 32'(pixel_row);   // row flip

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd   <= cmd;
      s1_px    <= $signed({{34{query_x[31]}}, query_x}) * $signed({34'b0, x_grid_scale});
      s1_pz    <= $signed({{34{query_z[31]}}, query_z}) * $signed({34'b0, z_grid_scale});
      s1_we    <= (wcol32 < w32) && (32'(pixel_row) < l32);
      s1_wcol  <= wcol32[CW-1:0];
      s1_wrow  <= wrow32[RW-1:0];
      s1_wdata <= pixel_value;
    end
  end

  // ---------------- stage 2: cell, range check, bank read ----------------
  logic [IW-1:0] xi, zi;
  logic          inr;
  logic [CW-1:0] x, x1;
  logic [RW-1:0] z, z1;
  logic [WW-1:0] xe;
  logic [LW-1:0] ze;
  logic [WW-1:0] wm1;
  logic [LW-1:0] lm1;

  assign xi  = s1_px[63:2*F];
  assign zi  = s1_pz[63:2*F];
  assign inr = !s1_px[65] && !s1_pz[65]
               && (xi < {{(IW-WW){1'b0}}, w}) && (zi < {{(IW-LW){1'b0}}, l});
  assign x   = xi[CW-1:0];
  assign z   = zi[RW-1:0];
  assign xe  = WW'(x) + WW'(1);
  assign ze  = LW'(z) + LW'(1);
  assign wm1 = w - WW'(1);
  assign lm1 = l - LW'(1);
  assign x1  = (xe < w) ? xe[CW-1:0] : wm1[CW-1:0];   // clamp at the right edge
  assign z1  = (ze < l) ? ze[RW-1:0] : lm1[RW-1:0];   // clamp at the top edge

  logic [7:0] rd [4];
  logic       load_we;
  logic [CW:0] wcx;
  logic [RW:0] wrx;
  assign load_we = en && s1_v && (s1_cmd == CMD_LOAD) && s1_we;
  assign wcx = {1'b0, s1_wcol};
  assign wrx = {1'b0, s1_wrow};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = 1'((b >> 1) & 1);
    localparam logic RP = 1'(b & 1);
    logic [CW:0] rcx;
    logic [RW:0] rrx;
    assign rcx = {1'b0, (x[0] == CP) ? x : x1};
    assign rrx = {1'b0, (z[0] == RP) ? z : z1};

    hmtri_bank #(.AW(AW)) u_bank (
      .clk   (clk),
      .we    (load_we && (s1_wcol[0] == CP) && (s1_wrow[0] == RP)),
      .waddr ({wrx[RBW:1], wcx[CBW:1]}),
      .wdata (s1_wdata),
      .re    (en),
      .raddr ({rrx[RBW:1], rcx[CBW:1]}),
      .rdata (rd[b])
    );
  end

  logic         s2_v, s2_inr, s2_xp, s2_x1p, s2_zp, s2_z1p;
  logic [F-1:0] s2_fx, s2_fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v && (s1_cmd == CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_inr <= inr;
      s2_fx  <= s1_px[2*F-1:F];
      s2_fz  <= s1_pz[2*F-1:F];
      s2_xp  <= x[0];
      s2_x1p <= x1[0];
      s2_zp  <= z[0];
      s2_z1p <= z1[0];
    end
  end

  // ---------------- stage 3: triangle split, row interpolation ----------------
  logic signed [9:0] bl, br, tl, tr, br_c, tl_c;
  logic [F:0]        omfx, omfz;
  logic signed [TW-1:0] top, bot;

  assign bl = $signed({2'b0, rd[{s2_xp,  s2_zp}]});
  assign br = $signed({2'b0, rd[{s2_x1p, s2_zp}]});
  assign tl = $signed({2'b0, rd[{s2_xp,  s2_z1p}]});
  assign tr = $signed({2'b0, rd[{s2_x1p, s2_z1p}]});

  always_comb begin
    br_c = br;
    tl_c = tl;
    if (s2_fz >= s2_fx) br_c = bl + (tr - tl);
    else                tl_c = tr + (bl - br);
  end

  assign omfx = ONE - {1'b0, s2_fx};
  assign top  = tl_c * $signed({1'b0, omfx}) + tr   * $signed({2'b0, s2_fx});
  assign bot  = bl   * $signed({1'b0, omfx}) + br_c * $signed({2'b0, s2_fx});

  logic                 s3_v, s3_inr;
  logic signed [TW-1:0] s3_top, s3_bot;
  logic [F-1:0]         s3_fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_inr <= s2_inr;
      s3_top <= top;
      s3_bot <= bot;
      s3_fz  <= s2_fz;
    end
  end

  // ---------------- stage 4: column interpolation ----------------
  logic                 s4_v, s4_inr;
  logic signed [HW-1:0] s4_h;
  assign omfz = ONE - {1'b0, s3_fz};

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_inr <= s3_inr;
      s4_h   <= s3_bot * $signed({1'b0, omfz}) + s3_top * $signed({2'b0, s3_fz});
    end
  end

  // ---------------- stage 5: floor, gain (sign-magnitude) ----------------
  logic signed [HW-1:0] hf, hmag;
  logic                 hneg;
  logic [MW-1:0]        mag;
  assign hf   = s4_h >>> F;              // floor to F fraction bits
  assign hneg = hf[HW-1];
  assign hmag = hneg ? -hf : hf;
  assign mag  = hmag[MW-1:0];

  logic          s5_v, s5_inr, s5_neg;
  logic [PW-1:0] s5_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_inr  <= s4_inr;
      s5_neg  <= hneg;
      s5_prod <= PW'(mag) * PW'(height_gain);
    end
  end

  // ---------------- stage 6: offset, saturate, output register ----------------
  logic [PW-F-1:0]   sm;
  logic signed [42:0] sgn, res;
  logic signed [31:0] res_sat;
  assign sm  = s5_prod[PW-1:F];          // truncate toward zero on the magnitude
  assign sgn = s5_neg ? -$signed(43'(sm)) : $signed(43'(sm));
  assign res = sgn + 43'(height_offset);

  always_comb begin
    if (res > 43'sd2147483647)       res_sat = 32'sh7FFFFFFF;
    else if (res < -43'sd2147483648) res_sat = 32'sh80000000;
    else                             res_sat = res[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_range <= s5_inr;
      height   <= s5_inr ? res_sat : 32'sd0;
    end
  end

endmodule

// ----- sv/hmtri_bank.sv -----
// One heightmap bank: single write port, single registered read port.
`timescale 1ns / 1ps
module hmtri_bank #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/hmtri_checker.sv -----
// Port-level checks for the heightmap sampler, bound to the top level.
`timescale 1ns / 1ps
module hmtri_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] height,
  input logic        in_range
);

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> height == 32'd0)
    else $error("out-of-map item with nonzero height");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(height) && $stable(in_range))
    else $error("stalled item changed");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while pipeline frozen");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("item out right after reset");

endmodule

bind heightmap_triangle_height_sampler_top hmtri_checker u_hmtri_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .height    (height),
  .in_range  (in_range)
);
